/* hdl/rpg_pkg.sv */
// Shared types and constants for the row pattern grouper.
// Holds the input and result word structs and the row geometry.
// Depends on nothing; every other file in hdl/ uses it.
package rpg_pkg;

	// Row geometry: 2 bits per column, 8 columns in a 16-bit row field.
	localparam int COL_BITS    = 2;
	localparam int FIELD_COLS  = 8;
	localparam int ROW_W       = COL_BITS * FIELD_COLS;
	localparam int NUM_COLUMNS = 8;
	// Columns that can ever be active: the smaller of the column count and the field.
	localparam int ACT_LIM     = (NUM_COLUMNS < FIELD_COLS) ? NUM_COLUMNS : FIELD_COLS;

	// Default table depth.
	localparam int MAX_PATTERNS = 256;

	// Configuration register indexes.
	localparam logic CFG_COMPARE_PAIRS = 1'b0;
	localparam logic CFG_USED_COLUMNS  = 1'b1;
	localparam logic [3:0] USED_COLUMNS_RESET = 4'd8;

	// Input word.
	typedef struct packed {
		logic              start_of_set;
		logic [ROW_W-1:0]  row_a;
		logic [ROW_W-1:0]  row_b;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic [7:0] group_index;
		logic       is_new;
		logic       overflow;
	} out_word_t;

endpackage

/* hdl/rpg_row_former.sv */
// Forms the row key from one input word and the configuration.
// Masks unused columns and, in paired mode, builds the column equality mask.
// Depends on rpg_pkg.
module rpg_row_former (
	input  logic                       compare_pairs,
	input  logic [3:0]                 used_columns,
	input  logic [rpg_pkg::ROW_W-1:0]  row_a,
	input  logic [rpg_pkg::ROW_W-1:0]  row_b,
	output logic [rpg_pkg::ROW_W-1:0]  row
);

	logic [3:0] active_cols;

	// Saturate the column count to what the row can hold.
	assign active_cols = (used_columns > 4'(rpg_pkg::ACT_LIM)) ?
		4'(rpg_pkg::ACT_LIM) : used_columns;

	// Each column is either copied, replaced by an equality flag, or zeroed.
	always_comb begin
		row = '0;
		for (int c = 0; c < rpg_pkg::FIELD_COLS; c++) begin
			if (4'(c) < active_cols) begin
				if (compare_pairs) begin
					row[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS] =
						{1'b0, (row_a[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS] ==
						        row_b[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS])};
				end else begin
					row[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS] =
						row_a[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS];
				end
			end
		end
	end

endmodule

/* hdl/rpg_pattern_table.sv */
// Storage for the distinct patterns seen so far.
// One write port and one registered read port; contents are undefined until written.
// Depends on rpg_pkg.
module rpg_pattern_table #(
	parameter int DEPTH = rpg_pkg::MAX_PATTERNS,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [rpg_pkg::ROW_W-1:0]  wr_data,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [rpg_pkg::ROW_W-1:0]  rd_data
);

	logic [rpg_pkg::ROW_W-1:0] mem [DEPTH];
	logic [rpg_pkg::ROW_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/row_pattern_grouper_core.sv */
// Row pattern grouper: assigns each row the index of its distinct pattern in
// order of first appearance. Each search runs over the patterns stored since a
// start flag last cleared the table (at most MAX_PATTERNS) and ends early on a
// match. One shared comparator checks one stored pattern per cycle against the
// row, fed by the single registered read port of the pattern table. A stalled
// result side holds the block in its result state. The block takes one word at
// a time; a finished result waits in an output register while the next word is
// taken. No clearing pass runs after reset.
module row_pattern_grouper_core #(
	parameter int MAX_PATTERNS = rpg_pkg::MAX_PATTERNS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rpg_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rpg_pkg::out_word_t out_data,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data
);

	localparam int IDX_W = $clog2(MAX_PATTERNS);
	localparam int CNT_W = $clog2(MAX_PATTERNS + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	logic [1:0]                state_q;
	logic                      cfg_compare_pairs_q;
	logic [3:0]                cfg_used_columns_q;
	logic [rpg_pkg::ROW_W-1:0] row_formed;
	logic [rpg_pkg::ROW_W-1:0] row_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          idx_q;
	logic                      pend_q;
	logic [IDX_W-1:0]          pend_idx_q;
	logic [rpg_pkg::ROW_W-1:0] rd_data;
	logic                      in_take;
	logic                      issue;
	logic                      hit;
	logic                      miss;
	logic                      room;
	logic                      tbl_wr_en;
	logic [IDX_W-1:0]          res_grp_q;
	logic                      res_new_q;
	logic                      res_ovf_q;
	logic                      out_valid_q;
	rpg_pkg::out_word_t        out_q;
	logic [IDX_W+7:0]          grp_ext;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_compare_pairs_q <= 1'b0;
			cfg_used_columns_q  <= rpg_pkg::USED_COLUMNS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rpg_pkg::CFG_COMPARE_PAIRS: cfg_compare_pairs_q <= cfg_data[0];
				rpg_pkg::CFG_USED_COLUMNS:  cfg_used_columns_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Row key from the incoming word.
	rpg_row_former u_row_former (
		.compare_pairs (cfg_compare_pairs_q),
		.used_columns  (cfg_used_columns_q),
		.row_a         (in_data.row_a),
		.row_b         (in_data.row_b),
		.row           (row_formed)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;

	// Scan control: issue one read per cycle, compare the word read the cycle before.
	assign issue = (state_q == ST_SCAN) && (idx_q < count_q);
	assign hit   = (state_q == ST_SCAN) && pend_q && (rd_data == row_q);
	assign miss  = (state_q == ST_SCAN) && !pend_q && !(idx_q < count_q);
	assign room  = (count_q < CNT_W'(MAX_PATTERNS));
	assign tbl_wr_en = miss && room;

	rpg_pattern_table #(
		.DEPTH  (MAX_PATTERNS),
		.ADDR_W (IDX_W)
	) u_pattern_table (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (row_q),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// Sequencer and pattern count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (in_data.start_of_set) begin
							count_q <= '0;
						end
						idx_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						pend_q  <= 1'b0;
						state_q <= ST_RESULT;
					end else if (miss) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_RESULT;
					end else begin
						pend_q <= issue;
						if (issue) begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				end
				ST_RESULT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers for the item at work.
	always_ff @(posedge clk) begin
		if (in_take) begin
			row_q <= row_formed;
		end
		if (issue) begin
			pend_idx_q <= idx_q[IDX_W-1:0];
		end
		if (hit) begin
			res_grp_q <= pend_idx_q;
			res_new_q <= 1'b0;
			res_ovf_q <= 1'b0;
		end else if (miss) begin
			res_grp_q <= room ? count_q[IDX_W-1:0] : '0;
			res_new_q <= room;
			res_ovf_q <= !room;
		end
	end

	// The result word carries the low 8 bits of the index.
	assign grp_ext = {8'd0, res_grp_q};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && (!out_valid_q || out_ready)) begin
			out_q.group_index <= grp_ext[7:0];
			out_q.is_new      <= res_new_q;
			out_q.overflow    <= res_ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The pattern count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PATTERNS))
		else $error("pattern count beyond table depth");

	// A pending compare exists only while scanning.
	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_SCAN))
		else $error("compare pending outside the scan");

	// A miss with room appends exactly one pattern.
	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		(miss && room) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not advance the pattern count");

	// A result is never both new and overflowed.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.is_new && out_q.overflow))
		else $error("result flagged both new and overflow");

endmodule

/* tb/tb_row_pattern_grouper_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for row_pattern_grouper_core: directed table, then random row sets.
// Depends on rpg_pkg and core; checks results against typed rows or a pattern-table model.
module tb_row_pattern_grouper_core;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 6;
	localparam int RANDOM_ROWS    = 450;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = rpg_pkg::MAX_PATTERNS + 8;
	localparam int HOLD_PHASE     = 1;
	localparam int FILL_PHASE     = 3;
	localparam int N_DIR          = 23;

	// One directed row: the configuration it needs, the input word and, where chk is set,
	// the result expected for it.
	typedef struct packed {
		bit        pairs;
		bit [3:0]  cols;
		bit        sos;
		bit [15:0] row_a;
		bit [15:0] row_b;
		bit        chk;
		bit [7:0]  grp;
		bit        is_new;
		bit        ovf;
	} dir_row_t;

	localparam dir_row_t DIRECTED_ROWS [N_DIR] = '{
		// Plain rows, table empty after reset with no start flag.
		'{1'b0, 4'd8, 1'b0, 16'h0000, 16'h0000, 1'b1, 8'd0, 1'b1, 1'b0},
		'{1'b0, 4'd8, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 8'd1, 1'b1, 1'b0},
		'{1'b0, 4'd8, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 8'd0, 1'b0, 1'b0},
		'{1'b0, 4'd8, 1'b0, 16'hFFFF, 16'h0000, 1'b1, 8'd1, 1'b0, 1'b0},
		'{1'b0, 4'd8, 1'b0, 16'hAAAA, 16'h5555, 1'b1, 8'd2, 1'b1, 1'b0},
		'{1'b0, 4'd8, 1'b0, 16'h5555, 16'hAAAA, 1'b1, 8'd3, 1'b1, 1'b0},
		// The start flag clears the table.
		'{1'b0, 4'd8, 1'b1, 16'h5555, 16'h0000, 1'b1, 8'd0, 1'b1, 1'b0},
		'{1'b0, 4'd8, 1'b0, 16'h0000, 16'h0000, 1'b1, 8'd1, 1'b1, 1'b0},
		// One column in use, then none, then counts above the field that saturate.
		'{1'b0, 4'd1, 1'b0, 16'hFFFC, 16'hFFFF, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b0, 4'd1, 1'b0, 16'h0001, 16'h0000, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b0, 4'd0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b0, 4'd15, 1'b0, 16'hFFFF, 16'h0000, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b0, 4'd9, 1'b0, 16'hFFFF, 16'h0000, 1'b0, 8'd0, 1'b0, 1'b0},
		// Paired mode: the row is the column-wise equality of both inputs.
		'{1'b1, 4'd8, 1'b1, 16'h1234, 16'h1234, 1'b1, 8'd0, 1'b1, 1'b0},
		'{1'b1, 4'd8, 1'b0, 16'h0000, 16'hFFFF, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b1, 4'd8, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b1, 4'd4, 1'b0, 16'h00FF, 16'h00FF, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b1, 4'd4, 1'b0, 16'h12FF, 16'h34FF, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b1, 4'd0, 1'b0, 16'h0001, 16'h0002, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b1, 4'd15, 1'b0, 16'hAAAA, 16'hAAAB, 1'b0, 8'd0, 1'b0, 1'b0},
		// Plain and paired rows share one table.
		'{1'b0, 4'd8, 1'b0, 16'h5554, 16'h0000, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b0, 4'd8, 1'b0, 16'h8421, 16'h7BDE, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b0, 4'd8, 1'b1, 16'h8421, 16'h0000, 1'b1, 8'd0, 1'b1, 1'b0}
	};

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	rpg_pkg::in_word_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	rpg_pkg::out_word_t out_data;
	logic               cfg_wr_en = 1'b0;
	logic               cfg_index = rpg_pkg::CFG_COMPARE_PAIRS;
	logic [3:0]         cfg_data  = '0;

	// Model of the pattern table and the configuration registers.
	logic [rpg_pkg::ROW_W-1:0] pattern_tab [rpg_pkg::MAX_PATTERNS];
	int unsigned               pattern_cnt = 0;
	bit                        pairs_cfg   = 1'b0;
	bit [3:0]                  cols_cfg    = rpg_pkg::USED_COLUMNS_RESET;

	rpg_pkg::out_word_t expected_groups [$];
	int                 mismatch_cnt = 0;
	int                 rows_sent    = 0;
	int                 idle_cycles  = 0;
	bit                 hold_req     = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	row_pattern_grouper_core #(
		.MAX_PATTERNS(rpg_pkg::MAX_PATTERNS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Forms the row from the word, searches the table in storage order and appends the row
	// when it is unseen and there is room.
	function automatic rpg_pkg::out_word_t classify_row(input rpg_pkg::in_word_t w);
		logic [rpg_pkg::ROW_W-1:0] row;
		logic [1:0]                va;
		logic [1:0]                vb;
		int                        ncols;
		bit                        hit;
		rpg_pkg::out_word_t        res;
		res = '0;
		row = '0;
		hit = 1'b0;
		if (w.start_of_set) begin
			pattern_cnt = 0;
		end
		ncols = (cols_cfg > rpg_pkg::ACT_LIM) ? rpg_pkg::ACT_LIM : cols_cfg;
		for (int c = 0; c < ncols; c++) begin
			va = w.row_a[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS];
			vb = w.row_b[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS];
			row[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS] = pairs_cfg ? {1'b0, va == vb} : va;
		end
		for (int j = 0; j < pattern_cnt && !hit; j++) begin
			if (pattern_tab[j] == row) begin
				hit = 1'b1;
				res.group_index = 8'(j);
			end
		end
		if (!hit) begin
			if (pattern_cnt < rpg_pkg::MAX_PATTERNS) begin
				pattern_tab[pattern_cnt] = row;
				res.group_index = 8'(pattern_cnt);
				res.is_new = 1'b1;
				pattern_cnt++;
			end else begin
				res.overflow = 1'b1;
			end
		end
		return res;
	endfunction

	// Mostly back-to-back, sometimes a short gap, now and then a long one.
	function automatic int pick_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Offers one word, holds it until accepted and queues the result it must produce.
	task automatic send_row(input rpg_pkg::in_word_t w, input int gap, input bit typed,
		input rpg_pkg::out_word_t typed_res);
		rpg_pkg::out_word_t pred;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		pred = classify_row(w);
		expected_groups = {expected_groups, (typed ? typed_res : pred)};
		rows_sent++;
	endtask

	// Every word yields one result, so the core is idle once nothing is pending.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_groups.size() != 0) @(posedge clk);
	endtask

	task automatic set_config(input bit pairs, input bit [3:0] cols);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= rpg_pkg::CFG_COMPARE_PAIRS;
		cfg_data  <= {3'b000, pairs};
		@(posedge clk);
		cfg_index <= rpg_pkg::CFG_USED_COLUMNS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pairs_cfg = pairs;
		cols_cfg  = cols;
	endtask

	task automatic check_result(input rpg_pkg::out_word_t got);
		rpg_pkg::out_word_t want;
		if (expected_groups.size() == 0) begin
			mismatch_cnt++;
			$display("%0t: unexpected result: expected none, got group %0d new %0b ovf %0b",
				$time, got.group_index, got.is_new, got.overflow);
		end else begin
			want = expected_groups.pop_front();
			if (got.group_index !== want.group_index) begin
				mismatch_cnt++;
				$display("%0t: group_index mismatch: expected %0d, got %0d",
					$time, want.group_index, got.group_index);
			end
			if (got.is_new !== want.is_new) begin
				mismatch_cnt++;
				$display("%0t: is_new mismatch: expected %0b, got %0b",
					$time, want.is_new, got.is_new);
			end
			if (got.overflow !== want.overflow) begin
				mismatch_cnt++;
				$display("%0t: overflow mismatch: expected %0b, got %0b",
					$time, want.overflow, got.overflow);
			end
		end
	endtask

	// Result side: runs of steady ready, random ready with occasional stalls, and one long
	// hold on request so that the core backs up into its input.
	initial begin
		int stall_left;
		int mode_left;
		bit steady;
		bit rdy;
		stall_left = 0;
		mode_left  = 0;
		steady     = 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 150);
				steady = ($urandom_range(0, 3) == 0);
			end
			mode_left--;
			if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (steady) begin
				rdy = 1'b1;
			end else begin
				rdy = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 99) == 0) begin
					stall_left = $urandom_range(10, 40);
				end
			end
			out_ready <= rdy;
			@(posedge clk);
			if (out_valid && rdy) begin
				check_result(out_data);
			end
		end
	end

	// Ends the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no word moved for %0d cycles", $time, idle_cycles);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Input side: directed table, then random sets of rows.
	initial begin
		rpg_pkg::in_word_t  w;
		rpg_pkg::out_word_t typed_res;
		dir_row_t           d;
		bit [15:0]          pool [16];
		bit [15:0]          keep;
		bit [15:0]          a;
		bit [15:0]          b;
		bit [15:0]          base;
		bit [7:0]           dmask;
		bit [3:0]           cols;
		bit                 pairs;
		bit                 steady;
		bit                 sos_first;
		int                 pool_n;
		int                 set_len;
		int                 ncols;
		int                 phase;
		int                 k;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			d = DIRECTED_ROWS[i];
			if (d.pairs != pairs_cfg || d.cols != cols_cfg) begin
				set_config(d.pairs, d.cols);
			end
			w.start_of_set = d.sos;
			w.row_a = d.row_a;
			w.row_b = d.row_b;
			typed_res.group_index = d.grp;
			typed_res.is_new = d.is_new;
			typed_res.overflow = d.ovf;
			send_row(w, pick_gap(1'b0), d.chk, typed_res);
		end

		phase = 0;
		while (rows_sent < N_DIR + RANDOM_ROWS) begin
			if (phase == FILL_PHASE) begin
				// Fill the table with distinct rows, then mix repeats with unseen rows
				// that must overflow.
				set_config(1'b0, 4'(rpg_pkg::FIELD_COLS));
				base = $urandom;
				for (int i = 0; i < rpg_pkg::MAX_PATTERNS + 24; i++) begin
					if (i < rpg_pkg::MAX_PATTERNS) begin
						k = i;
					end else if ($urandom_range(0, 1) == 1) begin
						k = $urandom_range(0, rpg_pkg::MAX_PATTERNS - 1);
					end else begin
						k = $urandom_range(rpg_pkg::MAX_PATTERNS, 4000);
					end
					w.start_of_set = (i == 0);
					w.row_a = base + 16'(k) * 16'h9E37;
					w.row_b = $urandom;
					send_row(w, pick_gap((i % 64) < 32), 1'b0, '0);
				end
			end else begin
				pairs = $urandom_range(0, 1);
				case ($urandom_range(0, 9))
					0: begin
						cols = 4'd0;
					end
					1: begin
						cols = 4'd15;
					end
					2: begin
						cols = 4'd1;
					end
					3, 4, 5: begin
						cols = 4'(rpg_pkg::FIELD_COLS);
					end
					default: begin
						cols = $urandom_range(0, 15);
					end
				endcase
				set_config(pairs, cols);
				ncols = (cols > rpg_pkg::ACT_LIM) ? rpg_pkg::ACT_LIM : cols;
				keep = '0;
				for (int c = 0; c < ncols; c++) begin
					keep[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS] = 2'b11;
				end
				// A small pool of rows, or of differing-column masks in paired mode,
				// so that rows repeat and matches are common.
				pool_n = $urandom_range(1, 10);
				for (int p = 0; p < pool_n; p++) begin
					pool[p] = $urandom;
				end
				set_len = (phase == HOLD_PHASE) ? 40 : $urandom_range(4, 30);
				steady = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
				sos_first = ($urandom_range(0, 4) != 0);
				if (phase == HOLD_PHASE) begin
					hold_req = 1'b1;
				end
				for (int i = 0; i < set_len; i++) begin
					k = $urandom_range(0, pool_n - 1);
					a = $urandom;
					b = $urandom;
					if ($urandom_range(0, 3) != 0) begin
						if (pairs) begin
							b = a;
							dmask = pool[k][7:0];
							for (int c = 0; c < rpg_pkg::FIELD_COLS; c++) begin
								if (dmask[c]) begin
									b[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS] =
										a[c*rpg_pkg::COL_BITS +: rpg_pkg::COL_BITS] ^
										2'($urandom_range(1, 3));
								end
							end
						end else begin
							a = (pool[k] & keep) | (a & ~keep);
						end
					end
					w.start_of_set = (i == 0) ? sos_first : ($urandom_range(0, 39) == 0);
					w.row_a = a;
					w.row_b = b;
					send_row(w, pick_gap(steady), 1'b0, '0);
				end
			end
			phase++;
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
